// ===== src/socl_pkg.sv =====
// ============================================================================
// socl_pkg
// Shared widths, command and status codes for the score-ordered candidate list.
// ============================================================================
package socl_pkg;

    localparam int CMD_W      = 2;
    localparam int ID_PORT_W  = 16;
    localparam int SCORE_W    = 32;
    localparam int POS_W      = 6;
    localparam int RND_W      = 16;
    localparam int CNT_PORT_W = 7;
    localparam int STAT_W     = 2;

    typedef logic [CMD_W-1:0]  command_t;
    typedef logic [STAT_W-1:0] status_t;

    localparam command_t CMD_INSERT = 2'd0;
    localparam command_t CMD_READ   = 2'd1;
    localparam command_t CMD_PICK   = 2'd2;
    localparam command_t CMD_CLEAR  = 2'd3;

    localparam status_t ST_OK    = 2'd0;
    localparam status_t ST_EMPTY = 2'd1;
    localparam status_t ST_FULL  = 2'd2;
    localparam status_t ST_RANGE = 2'd3;

endpackage

// ===== src/socl_cmd_if.sv =====
// ============================================================================
// socl_cmd_if
// Command channel: valid/ready handshake with the command item fields.
// ============================================================================
interface socl_cmd_if
    import socl_pkg::*;
();
    logic                       valid;
    logic                       ready;
    command_t                   command;
    logic [ID_PORT_W-1:0]       item_id;
    logic signed [SCORE_W-1:0]  score;
    logic [POS_W-1:0]           position;
    logic [RND_W-1:0]           random_value;

    modport source (
        output valid, command, item_id, score, position, random_value,
        input  ready
    );

    modport sink (
        input  valid, command, item_id, score, position, random_value,
        output ready
    );
endinterface

// ===== src/socl_rsp_if.sv =====
// ============================================================================
// socl_rsp_if
// Result channel: valid/ready handshake with the result item fields.
// ============================================================================
interface socl_rsp_if
    import socl_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic [ID_PORT_W-1:0]       read_id;
    logic signed [SCORE_W-1:0]  read_score;
    logic [CNT_PORT_W-1:0]      entry_count;
    logic [ID_PORT_W-1:0]       head_id;
    logic [ID_PORT_W-1:0]       tail_id;
    status_t                    status;

    modport source (
        output valid, read_id, read_score, entry_count, head_id, tail_id, status,
        input  ready
    );

    modport sink (
        input  valid, read_id, read_score, entry_count, head_id, tail_id, status,
        output ready
    );
endinterface

// ===== src/score_ordered_candidate_list_top.sv =====
// ============================================================================
// score_ordered_candidate_list_top
// Candidate list kept sorted by signed Q16.16 score, highest first.
// ============================================================================
// Flow: clear, empty, full or range cases go straight to the result; read
//   adds a memory read; pick runs 16 remainder steps first; insert walks
//   from the tail, one entry per cycle, moving entries down (worst: all),
//   bound by the single memory write port; ready only while idle, one item at a time.
// Reset: count cleared at once, list empty; entry memories are not cleared.
// ============================================================================
module score_ordered_candidate_list_top
    import socl_pkg::*;
#(
    parameter int DEPTH   = 64,
    parameter int ID_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    socl_cmd_if.sink    cmd,
    socl_rsp_if.source  rsp
);

    localparam int AW  = $clog2(DEPTH);
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int IXW = (ID_BITS > ID_PORT_W) ? ID_BITS : ID_PORT_W;
    localparam int EW  = (CW > CNT_PORT_W) ? CW : CNT_PORT_W;
    localparam int PW  = (CW > POS_W) ? CW : POS_W;
    localparam int AXW = (AW > POS_W) ? AW : POS_W;
    localparam int BCW = $clog2(RND_W + 1);

    // Sequencer states
    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_MOD    = 3'd1;  // remainder steps for random pick
    localparam logic [2:0] S_SHIFT  = 3'd2;  // walk from tail, move entries down
    localparam logic [2:0] S_WRNEW  = 3'd3;  // new entry lands at the head
    localparam logic [2:0] S_RDWAIT = 3'd4;  // memory read data arriving
    localparam logic [2:0] S_RESULT = 3'd5;  // hand result to output register

    function automatic logic [ID_PORT_W-1:0] id_to_port(input logic [ID_BITS-1:0] v);
        logic [IXW-1:0] w;
        w = IXW'(v);
        return w[ID_PORT_W-1:0];
    endfunction

    // ------------------------------------------------------------------
    // Entry memories: one write and one registered read per cycle
    // ------------------------------------------------------------------
    logic [ID_BITS-1:0]         id_mem [DEPTH];
    logic signed [SCORE_W-1:0]  score_mem [DEPTH];

    logic                       wr_en;
    logic [AW-1:0]              wr_addr;
    logic [ID_BITS-1:0]         wr_id;
    logic signed [SCORE_W-1:0]  wr_score;
    logic [AW-1:0]              rd_addr;
    logic [ID_BITS-1:0]         rd_id_reg;
    logic signed [SCORE_W-1:0]  rd_score_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            id_mem[wr_addr]    <= wr_id;
            score_mem[wr_addr] <= wr_score;
        end
        rd_id_reg    <= id_mem[rd_addr];
        rd_score_reg <= score_mem[rd_addr];
    end

    // ------------------------------------------------------------------
    // Control and working registers
    // ------------------------------------------------------------------
    logic [2:0]                 state_reg, state_next;
    logic [CW-1:0]              count_reg, count_next;
    logic [ID_PORT_W-1:0]       head_reg, head_next;
    logic [ID_PORT_W-1:0]       tail_reg, tail_next;
    logic [AW-1:0]              idx_reg, idx_next;
    logic [CW-1:0]              rem_reg, rem_next;
    logic [RND_W-1:0]           rnd_reg, rnd_next;
    logic [BCW-1:0]             bit_cnt_reg, bit_cnt_next;
    logic [ID_BITS-1:0]         new_id_reg, new_id_next;
    logic signed [SCORE_W-1:0]  new_score_reg, new_score_next;
    logic [ID_PORT_W-1:0]       res_id_reg, res_id_next;
    logic signed [SCORE_W-1:0]  res_score_reg, res_score_next;
    status_t                    res_status_reg, res_status_next;

    // Output register
    logic                       out_valid_reg, out_valid_next;
    logic [ID_PORT_W-1:0]       out_id_reg, out_id_next;
    logic signed [SCORE_W-1:0]  out_score_reg, out_score_next;
    logic [CNT_PORT_W-1:0]      out_count_reg, out_count_next;
    logic [ID_PORT_W-1:0]       out_head_reg, out_head_next;
    logic [ID_PORT_W-1:0]       out_tail_reg, out_tail_next;
    status_t                    out_status_reg, out_status_next;

    // Input field views at the stored widths
    logic [IXW-1:0]             in_id_ext;
    logic [ID_BITS-1:0]         in_id;
    logic [AXW-1:0]             pos_ext;
    logic                       pos_out_of_range;
    logic [EW-1:0]              count_ext;

    // Remainder unit: one compare-subtract per cycle
    logic [CW:0]                mod_trial;
    logic [CW:0]                mod_diff;

    // Score comparator
    logic                       stored_greater;

    assign in_id_ext        = IXW'(cmd.item_id);
    assign in_id            = in_id_ext[ID_BITS-1:0];
    assign pos_ext          = AXW'(cmd.position);
    assign pos_out_of_range = PW'(cmd.position) >= PW'(count_reg);
    assign count_ext        = EW'(count_reg);

    assign mod_trial      = {rem_reg, rnd_reg[RND_W-1]};
    assign mod_diff       = mod_trial - {1'b0, count_reg};
    assign stored_greater = rd_score_reg > new_score_reg;

    assign cmd.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        idx_next        = idx_reg;
        rem_next        = rem_reg;
        rnd_next        = rnd_reg;
        bit_cnt_next    = bit_cnt_reg;
        new_id_next     = new_id_reg;
        new_score_next  = new_score_reg;
        res_id_next     = res_id_reg;
        res_score_next  = res_score_reg;
        res_status_next = res_status_reg;

        out_valid_next  = out_valid_reg;
        out_id_next     = out_id_reg;
        out_score_next  = out_score_reg;
        out_count_next  = out_count_reg;
        out_head_next   = out_head_reg;
        out_tail_next   = out_tail_reg;
        out_status_next = out_status_reg;

        wr_en    = 1'b0;
        wr_addr  = '0;
        wr_id    = '0;
        wr_score = '0;
        rd_addr  = '0;

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (cmd.valid)
                begin
                    new_id_next     = in_id;
                    new_score_next  = cmd.score;
                    res_id_next     = '0;
                    res_score_next  = '0;
                    res_status_next = ST_OK;
                    state_next      = S_RESULT;
                    case (cmd.command)
                        CMD_INSERT:
                        begin
                            if (count_reg == CW'(DEPTH))
                            begin
                                res_status_next = ST_FULL;
                            end
                            else if (count_reg == '0)
                            begin
                                wr_en      = 1'b1;
                                wr_id      = in_id;
                                wr_score   = cmd.score;
                                head_next  = id_to_port(in_id);
                                tail_next  = id_to_port(in_id);
                                count_next = CW'(1);
                            end
                            else
                            begin
                                // start the walk at the tail entry
                                idx_next   = AW'(count_reg - CW'(1));
                                rd_addr    = AW'(count_reg - CW'(1));
                                state_next = S_SHIFT;
                            end
                        end
                        CMD_CLEAR:
                        begin
                            count_next = '0;
                        end
                        CMD_READ:
                        begin
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else if (pos_out_of_range)
                            begin
                                res_status_next = ST_RANGE;
                            end
                            else
                            begin
                                rd_addr    = pos_ext[AW-1:0];
                                state_next = S_RDWAIT;
                            end
                        end
                        default:
                        begin
                            // random pick
                            if (count_reg == '0)
                            begin
                                res_status_next = ST_EMPTY;
                            end
                            else
                            begin
                                rem_next     = '0;
                                rnd_next     = cmd.random_value;
                                bit_cnt_next = BCW'(RND_W);
                                state_next   = S_MOD;
                            end
                        end
                    endcase
                end
            end

            S_MOD:
            begin
                if (bit_cnt_reg == '0)
                begin
                    // remainder is below count, so always a valid index
                    rd_addr    = rem_reg[AW-1:0];
                    state_next = S_RDWAIT;
                end
                else
                begin
                    if (mod_trial >= {1'b0, count_reg})
                    begin
                        rem_next = mod_diff[CW-1:0];
                    end
                    else
                    begin
                        rem_next = mod_trial[CW-1:0];
                    end
                    rnd_next     = {rnd_reg[RND_W-2:0], 1'b0};
                    bit_cnt_next = bit_cnt_reg - BCW'(1);
                end
            end

            S_SHIFT:
            begin
                // rd_*_reg holds entry idx_reg
                wr_en   = 1'b1;
                wr_addr = idx_reg + AW'(1);
                if (stored_greater)
                begin
                    wr_id      = new_id_reg;
                    wr_score   = new_score_reg;
                    if (CW'(idx_reg) + CW'(1) == count_reg)
                    begin
                        tail_next = id_to_port(new_id_reg);
                    end
                    count_next = count_reg + CW'(1);
                    state_next = S_RESULT;
                end
                else
                begin
                    wr_id    = rd_id_reg;
                    wr_score = rd_score_reg;
                    if (idx_reg == '0)
                    begin
                        state_next = S_WRNEW;
                    end
                    else
                    begin
                        idx_next = idx_reg - AW'(1);
                        rd_addr  = idx_reg - AW'(1);
                    end
                end
            end

            S_WRNEW:
            begin
                wr_en      = 1'b1;
                wr_id      = new_id_reg;
                wr_score   = new_score_reg;
                head_next  = id_to_port(new_id_reg);
                count_next = count_reg + CW'(1);
                state_next = S_RESULT;
            end

            S_RDWAIT:
            begin
                res_id_next    = id_to_port(rd_id_reg);
                res_score_next = rd_score_reg;
                state_next     = S_RESULT;
            end

            S_RESULT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_id_next     = res_id_reg;
                    out_score_next  = res_score_reg;
                    out_count_next  = count_ext[CNT_PORT_W-1:0];
                    out_head_next   = (count_reg == '0) ? '0 : head_reg;
                    out_tail_next   = (count_reg == '0) ? '0 : tail_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg       <= head_next;
        tail_reg       <= tail_next;
        idx_reg        <= idx_next;
        rem_reg        <= rem_next;
        rnd_reg        <= rnd_next;
        bit_cnt_reg    <= bit_cnt_next;
        new_id_reg     <= new_id_next;
        new_score_reg  <= new_score_next;
        res_id_reg     <= res_id_next;
        res_score_reg  <= res_score_next;
        res_status_reg <= res_status_next;
        out_id_reg     <= out_id_next;
        out_score_reg  <= out_score_next;
        out_count_reg  <= out_count_next;
        out_head_reg   <= out_head_next;
        out_tail_reg   <= out_tail_next;
        out_status_reg <= out_status_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.read_id     = out_id_reg;
    assign rsp.read_score  = out_score_reg;
    assign rsp.entry_count = out_count_reg;
    assign rsp.head_id     = out_head_reg;
    assign rsp.tail_id     = out_tail_reg;
    assign rsp.status      = out_status_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count above depth");

    a_walk_in_list: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SHIFT) |-> (CW'(idx_reg) < count_reg))
        else $error("insert walk outside the list");

    a_write_bound: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> ((CW + 1)'(wr_addr) <= (CW + 1)'(count_reg)))
        else $error("entry write beyond new tail");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.valid && cmd.ready && cmd.command == CMD_CLEAR) |=> (count_reg == '0))
        else $error("clear left entries");

    a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_RESULT && out_valid_reg && !rsp.ready) |=> (state_reg == S_RESULT))
        else $error("result overwrote an untaken item");

endmodule

// ===== tb/tb_score_ordered_candidate_list_top.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb_score_ordered_candidate_list_top
// Self-checking bench for the score-ordered candidate list. A directed table
// covers the empty, full-range and ordering corners. Random command runs
// follow, including full-list fills. Every result is checked field by field
// against the table's known value or an in-bench model of the sorted list.
// ============================================================================
module tb_score_ordered_candidate_list_top;
    import socl_pkg::*;

    localparam int LIST_DEPTH    = 64;
    localparam int RANDOM_ITEMS  = 900;
    localparam int DIRECTED_ROWS = 25;
    localparam int STEADY_FIRST  = 300;   // no idling on either side in this window
    localparam int STEADY_LAST   = 420;
    localparam int SETTLE_CYCLES = 80;

    typedef struct packed {
        command_t                  command;
        logic [ID_PORT_W-1:0]      item_id;
        logic signed [SCORE_W-1:0] score;
        logic [POS_W-1:0]          position;
        logic [RND_W-1:0]          random_value;
    } cmd_item_t;

    typedef struct packed {
        logic [ID_PORT_W-1:0]      read_id;
        logic signed [SCORE_W-1:0] read_score;
        logic [CNT_PORT_W-1:0]     entry_count;
        logic [ID_PORT_W-1:0]      head_id;
        logic [ID_PORT_W-1:0]      tail_id;
        status_t                   status;
    } list_result_t;

    // typed = 1: the known result is checked as written; otherwise the model decides
    typedef struct packed {
        cmd_item_t    stim;
        logic         typed;
        list_result_t known;
    } directed_row_t;

    localparam list_result_t NO_RESULT = '0;

    localparam directed_row_t DIRECTED [DIRECTED_ROWS] = '{
        // right after reset: nothing to read or pick, clear is harmless
        '{'{CMD_READ,   16'h0000, 32'sh0000_0000, 6'd0,  16'h0000}, 1'b1,
          '{16'h0000, 32'sh0000_0000, 7'd0, 16'h0000, 16'h0000, ST_EMPTY}},
        '{'{CMD_PICK,   16'hFFFF, 32'sh7FFF_FFFF, 6'd63, 16'hFFFF}, 1'b1,
          '{16'h0000, 32'sh0000_0000, 7'd0, 16'h0000, 16'h0000, ST_EMPTY}},
        '{'{CMD_CLEAR,  16'hFFFF, 32'sh8000_0000, 6'd63, 16'hFFFF}, 1'b1,
          '{16'h0000, 32'sh0000_0000, 7'd0, 16'h0000, 16'h0000, ST_OK}},
        // score extremes, id extremes
        '{'{CMD_INSERT, 16'hFFFF, 32'sh7FFF_FFFF, 6'd0,  16'h0000}, 1'b1,
          '{16'h0000, 32'sh0000_0000, 7'd1, 16'hFFFF, 16'hFFFF, ST_OK}},
        '{'{CMD_INSERT, 16'h0000, 32'sh8000_0000, 6'd0,  16'h0000}, 1'b1,
          '{16'h0000, 32'sh0000_0000, 7'd2, 16'hFFFF, 16'h0000, ST_OK}},
        '{'{CMD_READ,   16'h0000, 32'sh0000_0000, 6'd0,  16'h0000}, 1'b1,
          '{16'hFFFF, 32'sh7FFF_FFFF, 7'd2, 16'hFFFF, 16'h0000, ST_OK}},
        '{'{CMD_READ,   16'h0000, 32'sh0000_0000, 6'd1,  16'h0000}, 1'b1,
          '{16'h0000, 32'sh8000_0000, 7'd2, 16'hFFFF, 16'h0000, ST_OK}},
        // index past the tail, highest and just past
        '{'{CMD_READ,   16'h0000, 32'sh0000_0000, 6'd63, 16'h0000}, 1'b1,
          '{16'h0000, 32'sh0000_0000, 7'd2, 16'hFFFF, 16'h0000, ST_RANGE}},
        '{'{CMD_READ,   16'h0000, 32'sh0000_0000, 6'd2,  16'h0000}, 1'b1,
          '{16'h0000, 32'sh0000_0000, 7'd2, 16'hFFFF, 16'h0000, ST_RANGE}},
        // equal scores: newest goes first
        '{'{CMD_INSERT, 16'h1234, 32'sh0000_0000, 6'd0,  16'h0000}, 1'b0, NO_RESULT},
        '{'{CMD_INSERT, 16'h5678, 32'sh0000_0000, 6'd0,  16'h0000}, 1'b0, NO_RESULT},
        '{'{CMD_INSERT, 16'h00AA, 32'sh7FFF_FFFF, 6'd0,  16'h0000}, 1'b0, NO_RESULT},
        '{'{CMD_INSERT, 16'h00BB, 32'sh8000_0000, 6'd0,  16'h0000}, 1'b0, NO_RESULT},
        // +1.0 and -1.0 in Q16.16
        '{'{CMD_INSERT, 16'h8001, 32'sh0001_0000, 6'd0,  16'h0000}, 1'b0, NO_RESULT},
        '{'{CMD_INSERT, 16'h7FFE, 32'shFFFF_0000, 6'd0,  16'h0000}, 1'b0, NO_RESULT},
        '{'{CMD_READ,   16'h0000, 32'sh0000_0000, 6'd0,  16'h0000}, 1'b0, NO_RESULT},
        '{'{CMD_READ,   16'h0000, 32'sh0000_0000, 6'd3,  16'h0000}, 1'b0, NO_RESULT},
        '{'{CMD_READ,   16'h0000, 32'sh0000_0000, 6'd7,  16'h0000}, 1'b0, NO_RESULT},
        '{'{CMD_PICK,   16'h0000, 32'sh0000_0000, 6'd0,  16'h0000}, 1'b0, NO_RESULT},
        '{'{CMD_PICK,   16'h0000, 32'sh0000_0000, 6'd0,  16'hFFFF}, 1'b0, NO_RESULT},
        '{'{CMD_PICK,   16'h0000, 32'sh0000_0000, 6'd0,  16'h0007}, 1'b0, NO_RESULT},
        '{'{CMD_READ,   16'h0000, 32'sh0000_0000, 6'd8,  16'h0000}, 1'b0, NO_RESULT},
        // clear a populated list, then the list must act empty again
        '{'{CMD_CLEAR,  16'h0000, 32'sh0000_0000, 6'd0,  16'h0000}, 1'b1,
          '{16'h0000, 32'sh0000_0000, 7'd0, 16'h0000, 16'h0000, ST_OK}},
        '{'{CMD_READ,   16'h0000, 32'sh0000_0000, 6'd0,  16'h0000}, 1'b1,
          '{16'h0000, 32'sh0000_0000, 7'd0, 16'h0000, 16'h0000, ST_EMPTY}},
        '{'{CMD_INSERT, 16'h0001, 32'shFFFF_FFFF, 6'd0,  16'h0000}, 1'b1,
          '{16'h0000, 32'sh0000_0000, 7'd1, 16'h0001, 16'h0001, ST_OK}}
    };

    logic clk;
    logic rst_n;

    socl_cmd_if cmd_bus ();
    socl_rsp_if rsp_bus ();

    score_ordered_candidate_list_top #(
        .DEPTH   (LIST_DEPTH),
        .ID_BITS (ID_PORT_W)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .rsp   (rsp_bus)
    );

    // Model of the list contents; updated when a command is accepted.
    logic [ID_PORT_W-1:0]      held_id    [LIST_DEPTH];
    logic signed [SCORE_W-1:0] held_score [LIST_DEPTH];
    int                        held_count;

    list_result_t pending_results [$];
    int           error_count = 0;
    int           result_index = 0;
    int           random_sent;
    bit           steady;

    // 8 ns clock
    initial clk = 1'b0;
    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Hard stop in case the handshake hangs
    initial
    begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    // Sorted insert: walk past every strictly greater score, so the new entry
    // lands ahead of all entries with an equal or lower score.
    function automatic list_result_t apply_command(input cmd_item_t c);
        list_result_t r;
        int           slot;
        int           k;
        r = '0;
        case (c.command)
            CMD_INSERT:
            begin
                if (held_count >= LIST_DEPTH)
                    r.status = ST_FULL;
                else
                begin
                    slot = 0;
                    while (slot < held_count && held_score[slot] > $signed(c.score))
                        slot++;
                    for (k = held_count; k > slot; k--)
                    begin
                        held_id[k]    = held_id[k-1];
                        held_score[k] = held_score[k-1];
                    end
                    held_id[slot]    = c.item_id;
                    held_score[slot] = c.score;
                    held_count++;
                end
            end
            CMD_CLEAR:
                held_count = 0;
            default:
            begin
                if (held_count == 0)
                    r.status = ST_EMPTY;
                else
                begin
                    if (c.command == CMD_READ)
                        slot = int'(c.position);
                    else
                        slot = int'(c.random_value) % held_count;
                    if (slot >= held_count)
                        r.status = ST_RANGE;
                    else
                    begin
                        r.read_id    = held_id[slot];
                        r.read_score = held_score[slot];
                    end
                end
            end
        endcase
        r.entry_count = CNT_PORT_W'(held_count);
        if (held_count != 0)
        begin
            r.head_id = held_id[0];
            r.tail_id = held_id[held_count-1];
        end
        return r;
    endfunction

    // Mix of extremes, a narrow band that produces many ties, and full range
    function automatic logic signed [SCORE_W-1:0] next_score();
        logic signed [SCORE_W-1:0] s;
        int                        pick;
        pick = $urandom_range(0, 99);
        if (pick < 15)
        begin
            case ($urandom_range(0, 5))
                0:       s = 32'sh8000_0000;
                1:       s = 32'sh7FFF_FFFF;
                2:       s = 32'sh0000_0000;
                3:       s = 32'shFFFF_FFFF;
                4:       s = 32'sh0001_0000;
                default: s = 32'shFFFF_0000;
            endcase
        end
        else if (pick < 45)
            s = {16'($urandom_range(0, 7)) - 16'd4, 16'h0000};
        else
            s = SCORE_W'($urandom);
        return s;
    endfunction

    function automatic cmd_item_t make_item(input command_t op);
        cmd_item_t it;
        it.command      = op;
        it.item_id      = ID_PORT_W'($urandom);
        it.score        = next_score();
        it.random_value = RND_W'($urandom);
        // half the reads land inside the list, the rest anywhere
        if (held_count != 0 && $urandom_range(0, 1) == 1)
            it.position = POS_W'($urandom_range(0, held_count - 1));
        else
            it.position = POS_W'($urandom);
        return it;
    endfunction

    function automatic void flag_error(input string what);
        error_count++;
        if (error_count <= 10)
            $display("mismatch at result %0d: %s", result_index, what);
    endfunction

    // Drive one item and hold it until accepted; predict on acceptance.
    task automatic push_command(input cmd_item_t it, input logic typed,
                                input list_result_t known);
        list_result_t predicted;
        while (!steady && $urandom_range(0, 99) < 33)
        begin
            cmd_bus.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_bus.valid        <= 1'b1;
        cmd_bus.command      <= it.command;
        cmd_bus.item_id      <= it.item_id;
        cmd_bus.score        <= it.score;
        cmd_bus.position     <= it.position;
        cmd_bus.random_value <= it.random_value;
        @(posedge clk);
        while (!cmd_bus.ready)
            @(posedge clk);
        predicted = apply_command(it);
        pending_results.insert(pending_results.size(), typed ? known : predicted);
    endtask

    task automatic push_random(input command_t op);
        steady = (random_sent >= STEADY_FIRST && random_sent < STEADY_LAST);
        push_command(make_item(op), 1'b0, NO_RESULT);
        random_sent++;
    endtask

    task automatic wait_for_drain();
        cmd_bus.valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_result();
        list_result_t got;
        list_result_t want;
        got.read_id     = rsp_bus.read_id;
        got.read_score  = rsp_bus.read_score;
        got.entry_count = rsp_bus.entry_count;
        got.head_id     = rsp_bus.head_id;
        got.tail_id     = rsp_bus.tail_id;
        got.status      = rsp_bus.status;
        if (pending_results.size() == 0)
            flag_error("result with nothing outstanding");
        else
        begin
            want = pending_results.pop_front();
            if (got.read_id !== want.read_id)
                flag_error($sformatf("read_id exp %h got %h", want.read_id, got.read_id));
            if (got.read_score !== want.read_score)
                flag_error($sformatf("read_score exp %h got %h",
                                     want.read_score, got.read_score));
            if (got.entry_count !== want.entry_count)
                flag_error($sformatf("entry_count exp %0d got %0d",
                                     want.entry_count, got.entry_count));
            if (got.head_id !== want.head_id)
                flag_error($sformatf("head_id exp %h got %h", want.head_id, got.head_id));
            if (got.tail_id !== want.tail_id)
                flag_error($sformatf("tail_id exp %h got %h", want.tail_id, got.tail_id));
            if (got.status !== want.status)
                flag_error($sformatf("status exp %0d got %0d", want.status, got.status));
        end
        result_index++;
    endtask

    // Result side: check on each accepted item, then pick the next ready.
    always @(posedge clk)
    begin
        if (rst_n && rsp_bus.valid && rsp_bus.ready)
            check_result();
        rsp_bus.ready <= steady || ($urandom_range(0, 99) >= 33);
    end

    initial
    begin
        int       row;
        int       phase;
        int       run_len;
        int       extra;
        int       k;
        int       roll;
        command_t op;

        rst_n                = 1'b0;
        cmd_bus.valid        = 1'b0;
        cmd_bus.command      = CMD_INSERT;
        cmd_bus.item_id      = '0;
        cmd_bus.score        = '0;
        cmd_bus.position     = '0;
        cmd_bus.random_value = '0;
        held_count           = 0;
        random_sent          = 0;
        steady               = 1'b0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed corners
        for (row = 0; row < DIRECTED_ROWS; row++)
            push_command(DIRECTED[row].stim, DIRECTED[row].typed, DIRECTED[row].known);

        // Let everything come back before going random
        wait_for_drain();

        // Random runs. Fill runs take the list from empty to full and then
        // push a few inserts that must be dropped. Mixed runs are mostly
        // inserts, reads and picks with a rare clear so the list grows deep.
        while (random_sent < RANDOM_ITEMS)
        begin
            phase = $urandom_range(0, 9);
            if (phase < 3)
            begin
                push_random(CMD_CLEAR);
                while (held_count < LIST_DEPTH)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 85)
                        push_random(CMD_INSERT);
                    else if (roll < 93)
                        push_random(CMD_READ);
                    else
                        push_random(CMD_PICK);
                end
                extra = $urandom_range(1, 4);
                for (k = 0; k < extra; k++)
                    push_random(CMD_INSERT);
                for (k = 0; k < 4; k++)
                    push_random(($urandom_range(0, 1) == 1) ? CMD_READ : CMD_PICK);
            end
            else
            begin
                // an idle pause with nothing outstanding, now and then
                if (phase == 9)
                    wait_for_drain();
                run_len = $urandom_range(20, 60);
                for (k = 0; k < run_len; k++)
                begin
                    roll = $urandom_range(0, 99);
                    if (roll < 45)
                        op = CMD_INSERT;
                    else if (roll < 70)
                        op = CMD_READ;
                    else if (roll < 98)
                        op = CMD_PICK;
                    else
                        op = CMD_CLEAR;
                    push_random(op);
                end
            end
        end

        steady = 1'b0;
        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/socl_pkg.sv
src/socl_cmd_if.sv
src/socl_rsp_if.sv
src/score_ordered_candidate_list_top.sv
tb/tb_score_ordered_candidate_list_top.sv
